// ===== rtl/core/request_table_search_remove_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Request table search/remove unit - assertion macros
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_TABLE_SEARCH_REMOVE_UNIT_MACROS_SVH
`define REQUEST_TABLE_SEARCH_REMOVE_UNIT_MACROS_SVH

// same-cycle implication
`define RTSR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtsr: same-cycle check failed");

// next-cycle implication
`define RTSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtsr: next-cycle check failed");

`endif

// ===== rtl/core/rtsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rtsr_pkg
// Types, command and status codes of the request table search/remove unit.
// ----------------------------------------------------------------------------
package rtsr_pkg;

   // default table depth
   localparam int TABLE_DEPTH_C = 16;

   // field widths fixed by the interface
   localparam int KIND_W   = 3;
   localparam int CLIENT_W = 8;
   localparam int PAY_W    = 16;
   localparam int POS_W    = 4;
   localparam int FILL_W   = 5;
   localparam int STAT_W   = 2;
   localparam int POS_RANGE = 1 << POS_W;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TAKE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INSPECT = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

   // request channel payload
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CLIENT_W-1:0] client_id;
      logic                prio;
      logic [PAY_W-1:0]    payload;
      logic [POS_W-1:0]    position;
   } req_type;

   // response channel payload
   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic                found;
      logic [CLIENT_W-1:0] out_client;
      logic                out_prio;
      logic [PAY_W-1:0]    out_payload;
      logic [FILL_W-1:0]   fill_count;
      logic [POS_W-1:0]    first_standard_pos;
      logic [POS_W-1:0]    first_premium_pos;
      logic                client_present;
      logic                all_same_prio;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      logic                prio;
      logic [PAY_W-1:0]    payload;
   } ent_type;

   // command token that walks down the cell chain
   typedef struct packed {
      logic             active;
      req_type          req;
      logic             full;      // insert on a full table
      logic             removing;  // an entry at or above this cell was removed
      logic             found;
      ent_type          ent;       // returned entry
      logic             have_std;
      logic [POS_W-1:0] fstd;
      logic             have_prem;
      logic [POS_W-1:0] fprem;
      logic             present;
   } tok_type;

endpackage

// ===== rtl/core/rtsr_cell.sv =====
// ----------------------------------------------------------------------------
// rtsr_cell
// One table slot. Holds an entry, applies the passing command token to it
// and folds its post-step value into the token's running summary.
// ----------------------------------------------------------------------------
module rtsr_cell
   import rtsr_pkg::*;
#(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] count,
   input  tok_type       tok_in,
   input  ent_type       next_ent,
   output tok_type       tok_out,
   output ent_type       ent
);

   localparam logic [CW-1:0] IDX_C  = CW'(INDEX);
   localparam logic [CW-1:0] IDX1_C = CW'(INDEX + 1);

   tok_type tok_ff, tok_nx_in;
   ent_type ent_ff, ent_in;
   logic    ins_ok, valid, pos_hit, cond, hit, shift, post_valid;

   // apply command to this slot
   always_comb begin
      ins_ok  = (tok_in.req.kind == KIND_INSERT) && !tok_in.full;
      valid   = IDX_C < count;
      pos_hit = (INDEX < POS_RANGE) && (tok_in.req.position == POS_W'(INDEX));
      unique case (tok_in.req.kind)
         KIND_TAKE:                 cond = (ent_ff.client == tok_in.req.client_id);
         KIND_POP:                  cond = (INDEX == 0);
         KIND_DELETE, KIND_INSPECT: cond = pos_hit;
         default:                   cond = 1'b0;
      endcase
      hit   = tok_in.active && valid && !tok_in.found && cond;
      shift = tok_in.active &&
              (tok_in.removing || (hit && (tok_in.req.kind != KIND_INSPECT)));

      // new slot content: close the gap, or append at the tail
      ent_in = ent_ff;
      if (shift) begin
         ent_in = next_ent;
      end else if (tok_in.active && ins_ok && (IDX_C == count)) begin
         ent_in.client  = tok_in.req.client_id;
         ent_in.prio    = tok_in.req.prio;
         ent_in.payload = tok_in.req.payload;
      end

      // slot holds an entry after the step
      if (shift) begin
         post_valid = IDX1_C < count;
      end else if (ins_ok) begin
         post_valid = IDX_C <= count;
      end else begin
         post_valid = valid;
      end

      // token update
      tok_nx_in = tok_in;
      if (hit) begin
         tok_nx_in.found = 1'b1;
         tok_nx_in.ent   = ent_ff;
      end
      tok_nx_in.removing = shift;
      if (tok_in.active && post_valid) begin
         if (ent_in.prio) begin
            if (!tok_in.have_prem) begin
               tok_nx_in.have_prem = 1'b1;
               tok_nx_in.fprem     = POS_W'(INDEX);
            end
         end else if (!tok_in.have_std) begin
            tok_nx_in.have_std = 1'b1;
            tok_nx_in.fstd     = POS_W'(INDEX);
         end
         if (ent_in.client == tok_in.req.client_id) begin
            tok_nx_in.present = 1'b1;
         end
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_nx_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign tok_out = tok_ff;
   assign ent     = ent_ff;

endmodule

// ===== rtl/core/rtsr_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// rtsr_rsp_buf
// Two-slot response buffer: output register plus one spare slot so the
// table can run the next command while a response is stalled.
// ----------------------------------------------------------------------------
module rtsr_rsp_buf
   import rtsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data,
   output logic    spare_full
);

   logic    main_valid_ff, spare_valid_ff;
   rsp_type main_ff, spare_ff;
   logic    take;

   assign take = main_valid_ff && !out_stall;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (!main_valid_ff || take) begin
         main_valid_ff  <= spare_valid_ff || in_valid;
         spare_valid_ff <= spare_valid_ff && in_valid;
      end else if (in_valid) begin
         spare_valid_ff <= 1'b1;
      end
   end

   // data slots
   always_ff @(posedge clock) begin
      if (!main_valid_ff || take) begin
         main_ff <= spare_valid_ff ? spare_ff : in_data;
         if (spare_valid_ff && in_valid) begin
            spare_ff <= in_data;
         end
      end else if (in_valid) begin
         spare_ff <= in_data;
      end
   end

   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;
   assign spare_full = spare_valid_ff;

endmodule

// ===== rtl/core/request_table_search_remove_unit.sv =====
// ----------------------------------------------------------------------------
// request_table_search_remove_unit
// Ordered table of pending requests with append, take by client, pop,
// delete and inspect, each answered with one response and a table summary.
//
// Request channel (req_valid / req_stall / req_data) carries one command.
// Response channel (rsp_valid / rsp_stall / rsp_data) returns one result
// per command, in order.
// A command walks a chain of TABLE_DEPTH slot cells, one cell per cycle;
// its response is registered from the last cell into the response buffer,
// and rsp_valid rises as it is.
// Commands run one at a time: req_stall drops as the previous response is
// registered, so the next request transfer can follow; a new command is
// not taken while one is still in the chain.
// While a response is stalled, one more command may run; its response goes
// to a spare slot and req_stall stays high until the spare drains.
// Reset empties the table (count to zero), idles the chain and drops any
// pending responses; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "request_table_search_remove_unit_macros.svh"

module request_table_search_remove_unit
   import rtsr_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_C
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          req_xfer, spare_full, ins_ok;
   tok_type       launch_tok, last;
   rsp_type       fin_rsp;
   tok_type       toks [TABLE_DEPTH];
   ent_type       ents [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] act_vec;

   assign req_stall = busy_ff || spare_full;
   assign req_xfer  = req_valid && !req_stall;

   // token entering the first cell
   always_comb begin
      launch_tok        = '0;
      launch_tok.active = req_xfer;
      launch_tok.req    = req_data;
      launch_tok.full   = (req_data.kind == KIND_INSERT) && (count_ff == DEPTH_C);
   end

   // slot cell chain
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      tok_type tok_src;
      ent_type nbr_ent;
      if (g == 0) begin : g_head
         assign tok_src = launch_tok;
      end else begin : g_body
         assign tok_src = toks[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign nbr_ent = ents[g];
      end else begin : g_link
         assign nbr_ent = ents[g+1];
      end
      rtsr_cell #(
         .CW    (CW),
         .INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .count    (count_ff),
         .tok_in   (tok_src),
         .next_ent (nbr_ent),
         .tok_out  (toks[g]),
         .ent      (ents[g])
      );
      assign act_vec[g] = toks[g].active;
   end

   assign last = toks[TABLE_DEPTH-1];

   // response and new count from the finished token
   always_comb begin
      ins_ok = (last.req.kind == KIND_INSERT) && !last.full;
      if (ins_ok) begin
         count_in = count_ff + ONE_C;
      end else if (last.removing) begin
         count_in = count_ff - ONE_C;
      end else begin
         count_in = count_ff;
      end

      fin_rsp = '0;
      unique case (last.req.kind)
         KIND_INSERT:
            fin_rsp.status = last.full ? STAT_FULL : STAT_OK;
         KIND_TAKE, KIND_POP, KIND_DELETE, KIND_INSPECT:
            fin_rsp.status = last.found ? STAT_OK : STAT_MISS;
         default:
            fin_rsp.status = STAT_OK;
      endcase
      fin_rsp.found              = last.found;
      fin_rsp.out_client         = last.ent.client;
      fin_rsp.out_prio           = last.ent.prio;
      fin_rsp.out_payload        = last.ent.payload;
      fin_rsp.fill_count         = FILL_W'(count_in);
      fin_rsp.first_standard_pos = last.fstd;
      fin_rsp.first_premium_pos  = last.fprem;
      fin_rsp.client_present     = last.present;
      fin_rsp.all_same_prio      = !(last.have_std && last.have_prem);

      busy_in = busy_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end else if (last.active) begin
         busy_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (last.active) begin
            count_ff <= count_in;
         end
      end
   end

   // response buffering
   rtsr_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (last.active),
      .in_data    (fin_rsp),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data),
      .spare_full (spare_full)
   );

   // checks
   `RTSR_ASSERT_IMPL(a_one_token, clock, reset, 1'b1, $onehot0(act_vec))
   `RTSR_ASSERT_IMPL(a_finish_busy, clock, reset, last.active, busy_ff && !spare_full)
   `RTSR_ASSERT_NEXT(a_full_holds, clock, reset, last.active && last.full, count_ff == DEPTH_C)
   `RTSR_ASSERT_IMPL(a_count_range, clock, reset, busy_ff, count_ff <= DEPTH_C)

endmodule

// ===== bench/tb_request_table_search_remove_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_request_table_search_remove_unit
// Self-checking bench for the request table search/remove unit. A queue of
// commands feeds a falling-edge driver; a rising-edge monitor keeps a shadow
// copy of the table, predicts the response of every request transfer and
// checks each response transfer field by field, in order. Directed corner
// cases come first, then phases of fill-, drain- and mixed-biased random
// commands, with random gaps on the request side and random response stalls.
// ----------------------------------------------------------------------------
module tb_request_table_search_remove_unit;
   import rtsr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = TABLE_DEPTH_C + 1;
   localparam int MAX_PRINTED = 100;

   // command kinds the unit answers without touching the table
   localparam logic [KIND_W-1:0] KIND_RESERVED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RESERVED_LAST  = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // stimulus and checking state
   req_type     cmd_queue[$];
   rsp_type     expected_rsp_q[$];
   ent_type     table_model[$];
   logic [7:0]  client_pool[8];
   int          queued_cnt   = 0;
   int          accepted_cnt = 0;
   int          fail_count   = 0;
   logic        req_taken    = 1'b0;
   int          req_gap_left = 0;
   int          req_calm_left = 0;
   int          stall_left   = 0;
   int          stall_calm_left = 0;

   request_table_search_remove_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Shadow table: apply one command and return the response it must produce
   function automatic rsp_type predict_table_step(req_type cmd);
      rsp_type rsp;
      ent_type ent;
      int      idx;
      int      premium;
      bit      have_std;
      bit      have_prem;
      rsp = '0;
      idx = -1;
      premium = 0;
      have_std = 1'b0;
      have_prem = 1'b0;
      case (cmd.kind)
         KIND_INSERT: begin
            if (table_model.size() >= TABLE_DEPTH_C) begin
               rsp.status = STAT_FULL;
            end else begin
               ent.client = cmd.client_id;
               ent.prio = cmd.prio;
               ent.payload = cmd.payload;
               table_model = {table_model, ent};
            end
         end
         KIND_TAKE, KIND_POP, KIND_DELETE, KIND_INSPECT: begin
            if (cmd.kind == KIND_TAKE) begin
               foreach (table_model[i])
                  if (idx < 0 && table_model[i].client == cmd.client_id) idx = i;
            end else if (cmd.kind == KIND_POP) begin
               if (table_model.size() > 0) idx = 0;
            end else if (int'(cmd.position) < table_model.size()) begin
               idx = int'(cmd.position);
            end
            if (idx < 0) begin
               rsp.status = STAT_MISS;
            end else begin
               rsp.found = 1'b1;
               rsp.out_client = table_model[idx].client;
               rsp.out_prio = table_model[idx].prio;
               rsp.out_payload = table_model[idx].payload;
               if (cmd.kind != KIND_INSPECT) table_model.delete(idx);
            end
         end
         default: ;
      endcase

      // summary of the table after the command
      foreach (table_model[i]) begin
         if (table_model[i].prio) begin
            premium++;
            if (!have_prem) begin
               have_prem = 1'b1;
               rsp.first_premium_pos = POS_W'(i);
            end
         end else if (!have_std) begin
            have_std = 1'b1;
            rsp.first_standard_pos = POS_W'(i);
         end
         if (table_model[i].client == cmd.client_id) rsp.client_present = 1'b1;
      end
      rsp.fill_count = FILL_W'(table_model.size());
      rsp.all_same_prio = (premium == 0 || premium == table_model.size());
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   task automatic compare_response(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         report_mismatch("status", int'(got.status), int'(want.status));
      if (got.found !== want.found)
         report_mismatch("found", int'(got.found), int'(want.found));
      if (got.out_client !== want.out_client)
         report_mismatch("out_client", int'(got.out_client), int'(want.out_client));
      if (got.out_prio !== want.out_prio)
         report_mismatch("out_prio", int'(got.out_prio), int'(want.out_prio));
      if (got.out_payload !== want.out_payload)
         report_mismatch("out_payload", int'(got.out_payload), int'(want.out_payload));
      if (got.fill_count !== want.fill_count)
         report_mismatch("fill_count", int'(got.fill_count), int'(want.fill_count));
      if (got.first_standard_pos !== want.first_standard_pos)
         report_mismatch("first_standard_pos", int'(got.first_standard_pos),
                         int'(want.first_standard_pos));
      if (got.first_premium_pos !== want.first_premium_pos)
         report_mismatch("first_premium_pos", int'(got.first_premium_pos),
                         int'(want.first_premium_pos));
      if (got.client_present !== want.client_present)
         report_mismatch("client_present", int'(got.client_present),
                         int'(want.client_present));
      if (got.all_same_prio !== want.all_same_prio)
         report_mismatch("all_same_prio", int'(got.all_same_prio),
                         int'(want.all_same_prio));
   endtask

   // Monitor: check response transfers, predict on request transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_rsp_q.size() == 0)
            report_mismatch("unexpected response, status", int'(rsp_data.status), 0);
         else
            compare_response(rsp_data, expected_rsp_q.pop_front());
      end
      if (!reset && req_valid && req_stall === 1'b0) begin
         expected_rsp_q = {expected_rsp_q, predict_table_step(req_data)};
         accepted_cnt++;
      end
      req_taken <= !reset && req_valid && req_stall === 1'b0;
   end

   // Request driver: next command after a transfer, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            req_data <= cmd_queue.pop_front();
            req_valid <= 1'b1;
            if (req_calm_left > 0) begin
               req_calm_left--;
            end else if ($urandom_range(0, 31) == 0) begin
               req_calm_left = $urandom_range(10, 40);
            end else begin
               req_gap_left = pick_idle_len();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall generator, with stall-free stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm_left > 0)
            stall_calm_left--;
         else if ($urandom_range(0, 63) == 0)
            stall_calm_left = $urandom_range(40, 200);
         else if ($urandom_range(0, 3) == 0)
            stall_left = pick_idle_len();
      end
   end

   task automatic post_cmd(input logic [KIND_W-1:0] kind, input logic [7:0] client,
                           input logic prio, input logic [15:0] payload,
                           input logic [3:0] position);
      req_type cmd;
      cmd.kind = kind;
      cmd.client_id = client;
      cmd.prio = prio;
      cmd.payload = payload;
      cmd.position = position;
      cmd_queue = {cmd_queue, cmd};
      queued_cnt++;
   endtask

   // wait until every queued command is transferred and answered
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (accepted_cnt != queued_cnt || expected_rsp_q.size() != 0);
   endtask

   // Random commands in phases that grow, shrink or churn the table
   task automatic post_random_cmds(input int count);
      int               insert_pct;
      int               phase_left;
      int               r;
      logic [KIND_W-1:0] kind;
      logic [7:0]       client;
      logic [3:0]       position;
      insert_pct = 50;
      phase_left = 0;
      for (int n = 0; n < count; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 75;
               1: insert_pct = 25;
               default: insert_pct = 50;
            endcase
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            kind = KIND_W'($urandom_range(KIND_RESERVED_FIRST, KIND_RESERVED_LAST));
         end else if (r < insert_pct) begin
            kind = KIND_INSERT;
         end else begin
            case ($urandom_range(0, 3))
               0: kind = KIND_TAKE;
               1: kind = KIND_POP;
               2: kind = KIND_DELETE;
               default: kind = KIND_INSPECT;
            endcase
         end
         client = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                  client_pool[$urandom_range(0, 7)];
         position = ($urandom_range(0, 1) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
         post_cmd(kind, client, 1'($urandom), 16'($urandom), position);
      end
   endtask

   // Stimulus and end of run
   initial begin
      foreach (client_pool[i]) client_pool[i] = 8'($urandom);
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // empty table: pop, out-of-range inspect, unused kinds
      post_cmd(KIND_POP, 8'h00, 1'b0, 16'h0000, 4'd0);
      post_cmd(KIND_INSPECT, 8'hFF, 1'b1, 16'hFFFF, 4'd15);
      for (int k = KIND_RESERVED_FIRST; k <= KIND_RESERVED_LAST; k++)
         post_cmd(KIND_W'(k), 8'($urandom), 1'($urandom), 16'($urandom), 4'($urandom));
      // fill to capacity with repeated clients and field extremes
      for (int i = 0; i < TABLE_DEPTH_C; i++)
         post_cmd(KIND_INSERT, (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : 8'(8'h40 + i % 5),
                  (i > 2) && (i % 3 != 0),
                  (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom), 4'($urandom));
      // insert on a full table is rejected
      post_cmd(KIND_INSERT, 8'hA5, 1'b1, 16'h1234, 4'd0);
      post_cmd(KIND_INSPECT, 8'h41, 1'b0, 16'h0000, 4'd15);
      post_cmd(KIND_DELETE, 8'hFF, 1'b0, 16'h0000, 4'd15);
      // take returns the oldest entry of the client; a gone client misses
      post_cmd(KIND_TAKE, 8'h41, 1'b0, 16'h0000, 4'd0);
      post_cmd(KIND_TAKE, 8'hFF, 1'b0, 16'h0000, 4'd0);
      post_cmd(KIND_POP, 8'h42, 1'b0, 16'h0000, 4'd0);
      post_cmd(KIND_DELETE, 8'h43, 1'b0, 16'h0000, 4'd13);
      wait_until_quiet();

      post_random_cmds(360);
      wait_until_quiet();
      post_random_cmds(360);
      wait_until_quiet();
      repeat (2 * LATENCY) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule
